[hdl/rbf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rbf_pkg;

    // parameter defaults
    localparam int DEPTH_DEFAULT      = 16;
    localparam int ITEM_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int SLOTS_W = 5;
    localparam int OP_W    = 2;
    localparam int DATA_W  = 32;
    localparam int OCC_W   = 4;

    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;
    localparam logic [OP_W-1:0] OP_STATUS = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic wr_en;     // store word at write pointer and advance
        logic rd_en;     // read word at read pointer and advance
        logic flush;     // both pointers back to zero
        logic load;      // capture a result into the output register
        logic from_mem;  // result of an accepted get, data from the read port
        logic acc;       // accepted flag for a result not from memory
    } cmd_t;

    // datapath to controller, status before the current word
    typedef struct packed {
        logic full;
        logic empty;
    } status_t;

endpackage

`default_nettype wire

[hdl/rbf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbf_ctrl
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [rbf_pkg::OP_W-1:0]   operation,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    input  wire rbf_pkg::status_t           stat,
    output rbf_pkg::cmd_t                   cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.from_mem = (state_reg == ST_READ);
        if (accept)
        begin
            unique case (operation)
                rbf_pkg::OP_PUT:
                begin
                    cmd.wr_en = !stat.full;
                    cmd.acc   = !stat.full;
                    cmd.load  = 1'b1;
                end
                rbf_pkg::OP_GET:
                begin
                    // a refused get answers at once, a real one waits for the read port
                    cmd.rd_en = !stat.empty;
                    cmd.load  = stat.empty;
                end
                rbf_pkg::OP_FLUSH:
                begin
                    cmd.flush = 1'b1;
                    cmd.acc   = 1'b1;
                    cmd.load  = 1'b1;
                end
                rbf_pkg::OP_STATUS:
                begin
                    cmd.acc  = 1'b1;
                    cmd.load = 1'b1;
                end
                default:
                begin
                    cmd.load = 1'b1;
                end
            endcase
        end
        if (state_reg == ST_READ)
        begin
            cmd.load = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cmd.rd_en) state_next = ST_READ;
            ST_READ: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[hdl/rbf_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbf_datapath
#(
    parameter int DEPTH      = rbf_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = rbf_pkg::ITEM_WIDTH_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [rbf_pkg::SLOTS_W-1:0]    cfg_write_data,
    input  wire logic [rbf_pkg::DATA_W-1:0]     put_data,
    input  wire rbf_pkg::cmd_t                  cmd,
    output rbf_pkg::status_t                    stat,
    output logic                                accepted,
    output logic [rbf_pkg::DATA_W-1:0]          read_data,
    output logic                                is_full,
    output logic                                is_empty,
    output logic [rbf_pkg::OCC_W-1:0]           occupancy
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // arithmetic width: holds DEPTH and the slot register
    localparam int AW    = (PTR_W + 1 > rbf_pkg::SLOTS_W) ? PTR_W + 1 : rbf_pkg::SLOTS_W;

    logic [rbf_pkg::SLOTS_W-1:0] slots_reg;
    logic [PTR_W-1:0]            rp_reg;
    logic [PTR_W-1:0]            rp_next;
    logic [PTR_W-1:0]            wp_reg;
    logic [PTR_W-1:0]            wp_next;
    logic [ITEM_WIDTH-1:0]       mem [DEPTH];
    logic [ITEM_WIDTH-1:0]       mem_rd_reg;
    logic [AW-1:0]               slots_ext;
    logic [AW-1:0]               ring_len;

    logic                        accepted_reg;
    logic [rbf_pkg::DATA_W-1:0]  read_data_reg;
    logic                        full_reg;
    logic                        empty_reg;
    logic [rbf_pkg::OCC_W-1:0]   occ_reg;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [AW-1:0] len);
        logic [AW-1:0] n;
        n = AW'(p) + AW'(1);
        return (n >= len) ? '0 : n[PTR_W-1:0];
    endfunction

    function automatic logic ring_full(input logic [PTR_W-1:0] rp,
                                       input logic [PTR_W-1:0] wp,
                                       input logic [AW-1:0] len);
        if (rp == '0)
            return AW'(wp) == (len - AW'(1));
        return AW'(rp) == (AW'(wp) + AW'(1));
    endfunction

    function automatic logic [rbf_pkg::OCC_W-1:0] ring_count(input logic [PTR_W-1:0] rp,
                                                             input logic [PTR_W-1:0] wp,
                                                             input logic [AW-1:0] len);
        logic [AW-1:0] c;
        if (wp >= rp)
            c = AW'(wp) - AW'(rp);
        else
            c = len - (AW'(rp) - AW'(wp));
        return c[rbf_pkg::OCC_W-1:0];
    endfunction

    // slot count limited to 2 .. DEPTH
    assign slots_ext = AW'(slots_reg);
    always_comb
    begin
        priority if (slots_ext < AW'(2))
            ring_len = AW'(2);
        else if (slots_ext > AW'(DEPTH))
            ring_len = AW'(DEPTH);
        else
            ring_len = slots_ext;
    end

    always_comb
    begin
        rp_next = rp_reg;
        wp_next = wp_reg;
        if (cmd.flush)
        begin
            rp_next = '0;
            wp_next = '0;
        end
        else
        begin
            if (cmd.wr_en) wp_next = advance(wp_reg, ring_len);
            if (cmd.rd_en) rp_next = advance(rp_reg, ring_len);
        end
    end

    assign stat.full  = ring_full(rp_reg, wp_reg, ring_len);
    assign stat.empty = (rp_reg == wp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= rbf_pkg::SLOTS_RESET;
            rp_reg    <= '0;
            wp_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en) slots_reg <= cfg_write_data;
            rp_reg <= rp_next;
            wp_reg <= wp_next;
        end
    end

    // storage, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en) mem[wp_reg] <= ITEM_WIDTH'(put_data);
        if (cmd.rd_en) mem_rd_reg <= mem[rp_reg];
    end

    // output word, status taken after the pointer update
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            accepted_reg  <= cmd.from_mem ? 1'b1 : cmd.acc;
            read_data_reg <= cmd.from_mem ? rbf_pkg::DATA_W'(mem_rd_reg) : '0;
            full_reg      <= ring_full(rp_next, wp_next, ring_len);
            empty_reg     <= (rp_next == wp_next);
            occ_reg       <= ring_count(rp_next, wp_next, ring_len);
        end
    end

    assign accepted  = accepted_reg;
    assign read_data = read_data_reg;
    assign is_full   = full_reg;
    assign is_empty  = empty_reg;
    assign occupancy = occ_reg;

endmodule

`default_nettype wire

[hdl/ring_buffer_fifo_top.sv]
// Ring buffer FIFO with one slot kept open: a ring of slots_in_use slots (limited to
// 2 .. DEPTH) holds at most slots_in_use-1 words. Each input word carries an operation
// (put, get, flush or status) and produces exactly one output word with the accepted
// flag, the data of an accepted get (zero otherwise) and the full, empty and occupancy
// status after the operation. A put, flush, status or refused get loads its result
// into the output register; an accepted get first goes through the registered read port.
// A new input word is taken only while the output register is empty or its result is
// taken in the same cycle, so a waiting result holds off the input.
// Write slots_in_use only while idle and flush afterwards; storage is not cleared, so a
// get must never reach an entry that was not written since reset.
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_fifo_top
#(
    parameter int DEPTH      = rbf_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = rbf_pkg::ITEM_WIDTH_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // slot count register
    input  wire logic                           cfg_write_en,
    input  wire logic [rbf_pkg::SLOTS_W-1:0]    cfg_write_data,
    // input words
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rbf_pkg::OP_W-1:0]       operation,
    input  wire logic [rbf_pkg::DATA_W-1:0]     put_data,
    // output words
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                accepted,
    output logic [rbf_pkg::DATA_W-1:0]          read_data,
    output logic                                is_full,
    output logic                                is_empty,
    output logic [rbf_pkg::OCC_W-1:0]           occupancy
);

    rbf_pkg::cmd_t    cmd;
    rbf_pkg::status_t stat;

    // handshakes, state machine and output valid
    rbf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // pointers, slot register, storage and output word
    rbf_datapath
    #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .put_data       (put_data),
        .cmd            (cmd),
        .stat           (stat),
        .accepted       (accepted),
        .read_data      (read_data),
        .is_full        (is_full),
        .is_empty       (is_empty),
        .occupancy      (occupancy)
    );

    // an accepted get blocks input while its read is registered, then presents its result
    a_get_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation == rbf_pkg::OP_GET && !stat.empty)
        |=> (!in_ready && !out_valid) ##1 out_valid)
        else $error("accepted get did not complete in two cycles");

    // every other operation answers in the next cycle
    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation != rbf_pkg::OP_GET || stat.empty))
        |=> out_valid)
        else $error("result missing after single cycle operation");

    // full and empty exclude each other, empty means nothing waiting
    a_status_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_full && is_empty) && (!is_empty || occupancy == '0))
        else $error("inconsistent status in result");

    // a refused put or get returns no data
    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (read_data == '0))
        else $error("refused operation returned data");

endmodule

`default_nettype wire

[tb/sv/tb_ring_buffer_fifo_top.sv]
`timescale 1ns / 1ps

module tb_ring_buffer_fifo_top;

    localparam int RING_DEPTH    = rbf_pkg::DEPTH_DEFAULT;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_WORDS   = 140;
    localparam int SETTLE_CYCLES = 4;
    // worst case is far below this even with both sides stalling
    localparam int CYCLE_LIMIT   = 400000;

    // one output word of the block
    typedef struct packed {
        logic                       acc;
        logic [rbf_pkg::DATA_W-1:0] rd;
        logic                       full;
        logic                       empty;
        logic [rbf_pkg::OCC_W-1:0]  occ;
    } fifo_status_t;

    // directed rows: a word checked by the predictor, a word with its
    // outcome typed in, or a slot count write
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_SLOTS
    } row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [rbf_pkg::OP_W-1:0]   op;
        logic [rbf_pkg::DATA_W-1:0] data;   // slot count in the low bits for ROW_SLOTS
        fifo_status_t               want;
    } directed_row_t;

    localparam fifo_status_t NO_WANT = '0;
    localparam int N_DIRECTED = 26;

    // reset state first, then the extremes of the ring and of the data
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_TYPED,   rbf_pkg::OP_STATUS, 32'h0000_0000,
          '{1'b1, 32'h0000_0000, 1'b0, 1'b1, 4'd0}},
        // get from an empty queue is refused
        '{ROW_TYPED,   rbf_pkg::OP_GET,    32'hFFFF_FFFF,
          '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 4'd0}},
        '{ROW_TYPED,   rbf_pkg::OP_PUT,    32'hFFFF_FFFF,
          '{1'b1, 32'h0000_0000, 1'b0, 1'b0, 4'd1}},
        '{ROW_TYPED,   rbf_pkg::OP_PUT,    32'h0000_0000,
          '{1'b1, 32'h0000_0000, 1'b0, 1'b0, 4'd2}},
        '{ROW_TYPED,   rbf_pkg::OP_GET,    32'h0000_0000,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd1}},
        '{ROW_TYPED,   rbf_pkg::OP_GET,    32'h0000_0000,
          '{1'b1, 32'h0000_0000, 1'b0, 1'b1, 4'd0}},
        '{ROW_PREDICT, rbf_pkg::OP_PUT,    32'h1234_5678, NO_WANT},
        '{ROW_TYPED,   rbf_pkg::OP_FLUSH,  32'h0000_0000,
          '{1'b1, 32'h0000_0000, 1'b0, 1'b1, 4'd0}},
        // slot count below range acts as two: capacity of one word
        '{ROW_SLOTS,   rbf_pkg::OP_STATUS, 32'h0000_0000, NO_WANT},
        '{ROW_TYPED,   rbf_pkg::OP_PUT,    32'hA5A5_A5A5,
          '{1'b1, 32'h0000_0000, 1'b1, 1'b0, 4'd1}},
        // put into a full queue is refused
        '{ROW_TYPED,   rbf_pkg::OP_PUT,    32'h5A5A_5A5A,
          '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 4'd1}},
        '{ROW_TYPED,   rbf_pkg::OP_GET,    32'h0000_0000,
          '{1'b1, 32'hA5A5_A5A5, 1'b0, 1'b1, 4'd0}},
        '{ROW_TYPED,   rbf_pkg::OP_GET,    32'h0000_0000,
          '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 4'd0}},
        // slot count above range acts as the full depth
        '{ROW_SLOTS,   rbf_pkg::OP_STATUS, 32'h0000_001F, NO_WANT},
        '{ROW_PREDICT, rbf_pkg::OP_PUT,    32'h8000_0001, NO_WANT},
        '{ROW_PREDICT, rbf_pkg::OP_PUT,    32'h7FFF_FFFE, NO_WANT},
        '{ROW_PREDICT, rbf_pkg::OP_PUT,    32'h0000_FFFF, NO_WANT},
        // shrink the ring with no flush: pointers past the end go stale
        '{ROW_SLOTS,   rbf_pkg::OP_STATUS, 32'h0000_0003, NO_WANT},
        '{ROW_PREDICT, rbf_pkg::OP_STATUS, 32'h0000_0000, NO_WANT},
        '{ROW_PREDICT, rbf_pkg::OP_GET,    32'h0000_0000, NO_WANT},
        '{ROW_PREDICT, rbf_pkg::OP_GET,    32'h0000_0000, NO_WANT},
        '{ROW_PREDICT, rbf_pkg::OP_GET,    32'h0000_0000, NO_WANT},
        '{ROW_PREDICT, rbf_pkg::OP_PUT,    32'hFFFF_0000, NO_WANT},
        '{ROW_PREDICT, rbf_pkg::OP_STATUS, 32'h0000_0000, NO_WANT},
        '{ROW_TYPED,   rbf_pkg::OP_FLUSH,  32'h0000_0000,
          '{1'b1, 32'h0000_0000, 1'b0, 1'b1, 4'd0}},
        '{ROW_SLOTS,   rbf_pkg::OP_STATUS, 32'h0000_0010, NO_WANT}
    };

    // slot count per random phase; every fourth phase skips the flush
    localparam logic [rbf_pkg::SLOTS_W-1:0] PHASE_SLOTS [PHASE_COUNT] = '{
        5'd2, 5'd16, 5'd0, 5'd7, 5'd31, 5'd5, 5'd1, 5'd9, 5'd17, 5'd3, 5'd16, 5'd12
    };

    // clock, reset and block ports, every bench-driven one known from time zero
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write_en = 1'b0;
    logic [rbf_pkg::SLOTS_W-1:0]    cfg_write_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [rbf_pkg::OP_W-1:0]       operation = rbf_pkg::OP_STATUS;
    logic [rbf_pkg::DATA_W-1:0]     put_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           accepted;
    logic [rbf_pkg::DATA_W-1:0]     read_data;
    logic                           is_full;
    logic                           is_empty;
    logic [rbf_pkg::OCC_W-1:0]      occupancy;

    // shadow copy of the queue, advanced once per accepted word
    logic [rbf_pkg::DATA_W-1:0]     shadow_store [RING_DEPTH];
    bit                             shadow_written [RING_DEPTH];
    logic [rbf_pkg::OCC_W-1:0]      shadow_head = '0;
    logic [rbf_pkg::OCC_W-1:0]      shadow_tail = '0;
    logic [rbf_pkg::SLOTS_W-1:0]    shadow_slots = rbf_pkg::SLOTS_RESET;

    // outcomes still owed by the block, oldest first
    fifo_status_t         owed_status [$];
    fifo_status_t         oldest_owed;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int words_sent = 0;
    int refused_puts = 0;
    int refused_gets = 0;
    int stale_gets = 0;
    int cycle_count = 0;

    ring_buffer_fifo_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .put_data       (put_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .read_data      (read_data),
        .is_full        (is_full),
        .is_empty       (is_empty),
        .occupancy      (occupancy)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d outcomes still owed",
                     cycle_count, owed_status.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ring length actually used: slot count clamped to 2 .. depth
    function automatic int ring_len();
        if (shadow_slots < 5'd2)
            return 2;
        if (int'(shadow_slots) > RING_DEPTH)
            return RING_DEPTH;
        return int'(shadow_slots);
    endfunction

    // full when the tail sits one slot behind the head, cyclically
    function automatic bit ring_full();
        if (shadow_head == '0)
            return int'(shadow_tail) == ring_len() - 1;
        return int'(shadow_head) == int'(shadow_tail) + 1;
    endfunction

    // a pointer at or past the ring end wraps to zero on its next step
    function automatic logic [rbf_pkg::OCC_W-1:0] next_slot(
        input logic [rbf_pkg::OCC_W-1:0] ptr);
        int n;
        n = int'(ptr) + 1;
        if (n >= ring_len() || n >= RING_DEPTH)
            n = 0;
        return rbf_pkg::OCC_W'(n);
    endfunction

    // apply one word to the shadow queue and return the status it yields
    function automatic fifo_status_t predict_fifo_step(
        input logic [rbf_pkg::OP_W-1:0] op,
        input logic [rbf_pkg::DATA_W-1:0] data);
        fifo_status_t r;
        int waiting;
        r = '0;
        r.acc = 1'b1;
        case (op)
            rbf_pkg::OP_PUT:
            begin
                if (ring_full())
                    r.acc = 1'b0;
                else
                begin
                    shadow_store[shadow_tail] = data;
                    shadow_written[shadow_tail] = 1'b1;
                    shadow_tail = next_slot(shadow_tail);
                end
            end
            rbf_pkg::OP_GET:
            begin
                if (shadow_head == shadow_tail)
                    r.acc = 1'b0;
                else
                begin
                    r.rd = shadow_store[shadow_head];
                    shadow_head = next_slot(shadow_head);
                end
            end
            rbf_pkg::OP_FLUSH:
            begin
                shadow_head = '0;
                shadow_tail = '0;
            end
            default:
            begin
            end
        endcase
        r.full = ring_full();
        r.empty = (shadow_head == shadow_tail);
        if (shadow_tail >= shadow_head)
            waiting = int'(shadow_tail) - int'(shadow_head);
        else
            waiting = ring_len() - (int'(shadow_head) - int'(shadow_tail));
        r.occ = rbf_pkg::OCC_W'(waiting);
        return r;
    endfunction

    // one line per mismatch, counted
    task automatic report_mismatch(input string what,
                                   input logic [rbf_pkg::DATA_W-1:0] got,
                                   input logic [rbf_pkg::DATA_W-1:0] want);
        $display("mismatch on result %0d: %s got %h expected %h",
                 results_checked, what, got, want);
        mismatch_count++;
    endtask

    // present one word, hold it until taken, then record what it owes
    task automatic send_word(input logic [rbf_pkg::OP_W-1:0] op,
                             input logic [rbf_pkg::DATA_W-1:0] data,
                             input bit use_typed, input fifo_status_t typed_want);
        fifo_status_t want;
        // random gap before the word, valid low for its whole length
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_valid  <= 1'b1;
        operation <= op;
        put_data  <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // taken at this edge; valid stays up for the caller to decide
        want = predict_fifo_step(op, data);
        if (use_typed)
            want = typed_want;
        if (op == rbf_pkg::OP_PUT && !want.acc)
            refused_puts++;
        if (op == rbf_pkg::OP_GET && !want.acc)
            refused_gets++;
        owed_status.push_back(want);
        words_sent++;
    endtask

    // drop valid, wait for every owed word, then let the read port settle
    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        while (owed_status.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // slot count write while the block is idle
    task automatic set_slots(input logic [rbf_pkg::SLOTS_W-1:0] value);
        wait_idle(SETTLE_CYCLES);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        shadow_slots = value;
    endtask

    // receiver: check the word taken at this edge, then pick the next ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_status.size() == 0)
                    report_mismatch("word with nothing owed, read_data", read_data, '0);
                else
                begin
                    oldest_owed = owed_status.pop_front();
                    if (accepted !== oldest_owed.acc)
                        report_mismatch("accepted", rbf_pkg::DATA_W'(accepted),
                                        rbf_pkg::DATA_W'(oldest_owed.acc));
                    if (read_data !== oldest_owed.rd)
                        report_mismatch("read_data", read_data, oldest_owed.rd);
                    if (is_full !== oldest_owed.full)
                        report_mismatch("is_full", rbf_pkg::DATA_W'(is_full),
                                        rbf_pkg::DATA_W'(oldest_owed.full));
                    if (is_empty !== oldest_owed.empty)
                        report_mismatch("is_empty", rbf_pkg::DATA_W'(is_empty),
                                        rbf_pkg::DATA_W'(oldest_owed.empty));
                    if (occupancy !== oldest_owed.occ)
                        report_mismatch("occupancy", rbf_pkg::DATA_W'(occupancy),
                                        rbf_pkg::DATA_W'(oldest_owed.occ));
                end
                results_checked++;
            end
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // stimulus
    initial
    begin
        logic [rbf_pkg::OP_W-1:0]   op;
        logic [rbf_pkg::DATA_W-1:0] data;
        bit                         filling;
        int                         pick;

        filling = 1'b1;
        foreach (shadow_written[i])
            shadow_written[i] = 1'b0;

        // first mode: sender idles less than the receiver stalls
        sender_idle_pct    = 36;
        receiver_stall_pct = 51;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_SLOTS)
                set_slots(DIRECTED_ROWS[i].data[rbf_pkg::SLOTS_W-1:0]);
            else
                send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data,
                          DIRECTED_ROWS[i].kind == ROW_TYPED, DIRECTED_ROWS[i].want);
        end

        // random phases, four per idling mode
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph / 4)
                0:
                begin
                    sender_idle_pct    = 36;
                    receiver_stall_pct = 51;
                end
                1:
                begin
                    sender_idle_pct    = 51;
                    receiver_stall_pct = 36;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            set_slots(PHASE_SLOTS[ph]);
            // usual software flow flushes after a slot change; some phases keep
            // the stale pointers to exercise the wrap of a pointer past the end
            if (ph % 4 != 3)
                send_word(rbf_pkg::OP_FLUSH, $urandom, 1'b0, NO_WANT);

            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // alternate fill and drain runs so full and empty are both reached
                if (filling && ring_full() && $urandom_range(0, 3) != 0)
                    filling = 1'b0;
                else if (!filling && shadow_head == shadow_tail && $urandom_range(0, 3) != 0)
                    filling = 1'b1;
                else if ($urandom_range(0, 99) < 4)
                    filling = !filling;

                pick = $urandom_range(0, 99);
                if (pick < 2)
                    op = rbf_pkg::OP_FLUSH;
                else if (pick < 7)
                    op = rbf_pkg::OP_STATUS;
                else if ($urandom_range(0, 99) < (filling ? 75 : 25))
                    op = rbf_pkg::OP_PUT;
                else
                    op = rbf_pkg::OP_GET;

                case ($urandom_range(0, 7))
                    0:       data = '0;
                    1:       data = '1;
                    default: data = $urandom;
                endcase

                // never read an entry that was not written since reset
                if (op == rbf_pkg::OP_GET && shadow_head != shadow_tail)
                begin
                    if (!shadow_written[shadow_head])
                        op = rbf_pkg::OP_STATUS;
                    else if (int'(shadow_head) >= ring_len())
                        stale_gets++;
                end

                send_word(op, data, 1'b0, NO_WANT);
            end
        end

        // drain and let any late word show up
        wait_idle(4 * SETTLE_CYCLES);

        $display("covered %0d words over %0d slot settings and three idling modes",
                 words_sent, PHASE_COUNT + 4);
        $display("checked %0d results: %0d refused puts, %0d refused gets, %0d stale gets",
                 results_checked, refused_puts, refused_gets, stale_gets);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
hdl/rbf_pkg.sv
hdl/rbf_ctrl.sv
hdl/rbf_datapath.sv
hdl/ring_buffer_fifo_top.sv
tb/sv/tb_ring_buffer_fifo_top.sv
